// ===== sv/fvcm_pkg.sv =====
package fvcm_pkg;

  localparam int CACHE_DEPTH = 32;
  localparam int FILL_W      = $clog2(CACHE_DEPTH + 1);
  localparam int CFG_W       = 6;
  localparam int VIDX_W      = 32;
  localparam int CNT_W       = 32;
  localparam int ATVR_W      = 18;
  localparam int FRAC_W      = 16;
  localparam int NUM_W       = CNT_W + 1 + FRAC_W + 1;
  localparam int DIV_STEPS   = ATVR_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0] CACHE_SIZE_RESET = CFG_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX          = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DSTART,
    ST_DIV,
    ST_PUSH
  } state_t;

  // Per-cycle control broadcast to every cell of the cache chain.
  typedef struct packed {
    logic probe;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== sv/fifo_vertex_cache_miss_counter_core.sv =====
// FIFO vertex cache miss counter.
//
// Input channel (in_valid/in_ready) carries one vertex index and a last flag.
// Output channel (out_valid/out_ready) returns one result per index: the hit
// flag and the running miss count of the group, and on the last index of a
// group also the average transform to vertex ratio in unsigned Q2.16.
// The configuration channel (cfg_valid/cfg_ready) writes cache_size; it is
// always ready and should only be used while the block is idle.
//
// One index is processed at a time. The cache is a chain of compare cells,
// newest entry first; all cells compare in the accept cycle and the chain
// shifts by one on a miss unless cache_size is zero. A normal index passes
// through the states ST_UPD and ST_PUSH; the last index of a group also
// passes through ST_DSTART and ST_DIV for the bit-serial ratio divider.
// A new index is taken once the previous result sits in the output register,
// so the receiver may stall without losing anything; a stalled result holds
// its payload until the transfer completes.
// Reset empties the cache, clears both counters and sets cache_size to 16.
module fifo_vertex_cache_miss_counter_core
  import fvcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [VIDX_W-1:0] vertex_index,
  input  logic              last_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [CNT_W-1:0]  miss_total,
  output logic [ATVR_W-1:0] atvr_q16,
  output logic              group_done
);

  state_t              state, state_next;
  logic [CFG_W-1:0]    cache_size;
  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   size_eff;
  logic [CNT_W-1:0]    miss_counter;
  logic [CNT_W-1:0]    index_counter;
  logic [CNT_W-1:0]    idx_next;
  logic [CNT_W-1:0]    miss_next;
  logic [VIDX_W-1:0]   vidx_r;
  logic                last_r;
  logic                res_hit;
  logic [CNT_W-1:0]    res_miss;
  logic [CNT_W-1:0]    res_idx;
  logic                hit_any;
  logic                accept;
  logic                out_load;
  cell_ctrl_t          ctrl;
  logic [CACHE_DEPTH-1:0] match_vec;
  logic [CACHE_DEPTH-1:0] occupied;
  logic [VIDX_W-1:0]   entries [CACHE_DEPTH];
  logic                div_start;
  logic                div_done;
  logic [ATVR_W-1:0]   div_quot;
  logic [NUM_W-1:0]    div_num;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign hit_any   = |match_vec;
  assign out_load  = (state == ST_PUSH) && (!out_valid || out_ready);
  assign div_start = (state == ST_DSTART);

  always_comb begin
    if (int'(cache_size) > CACHE_DEPTH) begin
      size_eff = FILL_W'(CACHE_DEPTH);
    end else begin
      size_eff = FILL_W'(cache_size);
    end
  end

  assign idx_next  = (index_counter == CNT_MAX) ? index_counter
                                                : index_counter + CNT_W'(1);
  assign miss_next = (hit_any || miss_counter == CNT_MAX) ? miss_counter
                                                          : miss_counter + CNT_W'(1);

  assign ctrl.probe = accept;
  assign ctrl.shift = (state == ST_UPD) && !hit_any && (size_eff != '0);

  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cell
    assign occupied[i] = FILL_W'(i) < fill;
    if (i == 0) begin : g_head
      fvcm_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[i]),
        .probe_index (vertex_index),
        .entry_in    (vidx_r),
        .entry       (entries[i]),
        .match       (match_vec[i])
      );
    end else begin : g_body
      fvcm_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[i]),
        .probe_index (vertex_index),
        .entry_in    (entries[i-1]),
        .entry       (entries[i]),
        .match       (match_vec[i])
      );
    end
  end

  // Rounded ratio: ((indices + misses) << 16 + indices / 2) / indices.
  assign div_num = (NUM_W'({1'b0, res_idx} + {1'b0, res_miss}) << FRAC_W)
                 + NUM_W'(res_idx >> 1);

  fvcm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (res_idx),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) begin
                   state_next = ST_UPD;
                 end
      ST_UPD:    state_next = last_r ? ST_DSTART : ST_PUSH;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV:    if (div_done) begin
                   state_next = ST_PUSH;
                 end
      ST_PUSH:   if (out_load) begin
                   state_next = ST_IDLE;
                 end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cache_size    <= CACHE_SIZE_RESET;
      fill          <= '0;
      miss_counter  <= '0;
      index_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        cache_size <= cfg_data;
      end
      if (state == ST_UPD) begin
        if (last_r) begin
          fill          <= '0;
          miss_counter  <= '0;
          index_counter <= '0;
        end else begin
          miss_counter  <= miss_next;
          index_counter <= idx_next;
          if (!hit_any) begin
            if (size_eff == '0) begin
              fill <= '0;
            end else if (fill >= size_eff) begin
              fill <= size_eff;
            end else begin
              fill <= fill + FILL_W'(1);
            end
          end
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vidx_r <= vertex_index;
      last_r <= last_index;
    end
    if (state == ST_UPD) begin
      res_hit  <= hit_any;
      res_miss <= miss_next;
      res_idx  <= idx_next;
    end
    if (out_load) begin
      hit        <= res_hit;
      miss_total <= res_miss;
      atvr_q16   <= last_r ? div_quot : '0;
      group_done <= last_r;
    end
  end

endmodule

// ===== sv/fvcm_cell.sv =====
module fvcm_cell
  import fvcm_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic              occupied,
  input  logic [VIDX_W-1:0] probe_index,
  input  logic [VIDX_W-1:0] entry_in,
  output logic [VIDX_W-1:0] entry,
  output logic              match
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= entry_in;
    end
    if (ctrl.probe) begin
      match <= occupied && (entry == probe_index);
    end
  end

endmodule

// ===== sv/fvcm_div.sv =====
module fvcm_div
  import fvcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [CNT_W-1:0]  den,
  output logic              done,
  output logic [ATVR_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CNT_W-1:0]     rem;
  logic [ATVR_W-1:0]    low;
  logic [CNT_W-1:0]     den_r;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_sub;
  logic                 ge;

  assign rem_sh  = {rem, low[ATVR_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // The quotient is known to fit in ATVR_W bits, so the upper part of the
  // dividend is already smaller than the divisor and seeds the remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NUM_W-1:ATVR_W];
      low   <= num[ATVR_W-1:0];
      den_r <= den;
      cnt   <= '0;
    end else if (busy) begin
      rem  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      low  <= {low[ATVR_W-2:0], 1'b0};
      quot <= {quot[ATVR_W-2:0], ge};
      cnt  <= cnt + DIV_CNT_W'(1);
    end
  end

endmodule

// ===== sv/fvcm_checker.sv =====
module fvcm_checker
  import fvcm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              hit,
  input logic [CNT_W-1:0]  miss_total,
  input logic [ATVR_W-1:0] atvr_q16,
  input logic              group_done
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(miss_total) && $stable(hit))
    else $error("output payload changed while stalled");

  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // The first index of a group always misses, so a hit implies a nonzero count.
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> miss_total != '0)
    else $error("hit reported with zero misses");

  a_ratio_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !group_done |-> atvr_q16 == '0)
    else $error("ratio nonzero outside group end");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && group_done |->
      atvr_q16 >= ATVR_W'(65536) && atvr_q16 <= ATVR_W'(131072))
    else $error("ratio out of range");

endmodule

bind fifo_vertex_cache_miss_counter_core fvcm_checker u_fvcm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hit        (hit),
  .miss_total (miss_total),
  .atvr_q16   (atvr_q16),
  .group_done (group_done)
);

// ===== bench/fifo_vertex_cache_miss_counter_core_tb.sv =====
module fifo_vertex_cache_miss_counter_core_tb
  import fvcm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RX_HOLD_CYCLES = 150;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 85;

  typedef struct packed {
    logic [VIDX_W-1:0] vidx;
    logic              last;
  } index_item_t;

  typedef struct packed {
    logic              hit;
    logic [CNT_W-1:0]  misses;
    logic [ATVR_W-1:0] atvr;
    logic              done;
  } access_result_t;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data     = '0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [VIDX_W-1:0] vertex_index = '0;
  logic              last_index   = 1'b0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic              hit;
  logic [CNT_W-1:0]  miss_total;
  logic [ATVR_W-1:0] atvr_q16;
  logic              group_done;

  fifo_vertex_cache_miss_counter_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vertex_index (vertex_index),
    .last_index   (last_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .miss_total   (miss_total),
    .atvr_q16     (atvr_q16),
    .group_done   (group_done)
  );

  always #4 clk = ~clk;

  // Expected cache contents and counters, oldest entry at index 0.
  logic [VIDX_W-1:0] held_index [CACHE_DEPTH];
  int unsigned       held_count;
  logic [CNT_W-1:0]  group_misses;
  logic [CNT_W-1:0]  group_indices;
  logic [CFG_W-1:0]  cache_size_reg;

  index_item_t    index_stream[$];
  access_result_t awaited_results[$];

  logic in_accepted = 1'b0;
  logic rx_hold_go  = 1'b0;
  logic rx_hold     = 1'b0;
  int   in_idle_pct  = 25;
  int   out_idle_pct = 25;

  int mismatches      = 0;
  int results_checked = 0;
  int indices_taken   = 0;
  int groups_closed   = 0;
  int size_writes     = 0;

  function automatic access_result_t vcache_access(logic [VIDX_W-1:0] vidx, logic last);
    access_result_t r;
    int unsigned    lim;
    int unsigned    drop;
    logic [63:0]    idx64;
    logic [63:0]    num;
    logic [63:0]    quot;
    r = '0;
    lim = (cache_size_reg > CACHE_DEPTH) ? CACHE_DEPTH : cache_size_reg;
    for (int k = 0; k < held_count; k++)
      if (held_index[k] == vidx) r.hit = 1'b1;
    if (group_indices != CNT_MAX) group_indices++;
    if (!r.hit) begin
      if (group_misses != CNT_MAX) group_misses++;
      if (lim == 0) begin
        held_count = 0;
      end else begin
        // A full (or oversized) cache keeps only its newest lim-1 entries.
        if (held_count >= lim) begin
          drop = held_count - (lim - 1);
          for (int k = 0; k < lim - 1; k++) held_index[k] = held_index[k + drop];
          held_count = lim - 1;
        end
        held_index[held_count] = vidx;
        held_count++;
      end
    end
    r.misses = group_misses;
    if (last) begin
      idx64  = 64'(group_indices);
      num    = (idx64 + 64'(group_misses)) << FRAC_W;
      quot   = (num + (idx64 >> 1)) / idx64;
      r.atvr = quot[ATVR_W-1:0];
      r.done = 1'b1;
      held_count    = 0;
      group_misses  = '0;
      group_indices = '0;
    end
    return r;
  endfunction

  // Input driver: a new index is offered only after the current one transferred.
  always @(negedge clk) begin
    index_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (index_stream.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = index_stream.pop_front();
        in_valid     <= 1'b1;
        vertex_index <= nxt.vidx;
        last_index   <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !rx_hold && ($urandom_range(99) >= out_idle_pct);
  end

  initial begin
    wait (rx_hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Monitor: checks results, then predicts for any index taken at this edge.
  always @(posedge clk) begin
    access_result_t want;
    access_result_t got;
    if (rst) begin
      in_accepted    <= 1'b0;
      cache_size_reg = CACHE_SIZE_RESET;
      held_count     = 0;
      group_misses   = '0;
      group_indices  = '0;
    end else begin
      in_accepted <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) begin
        cache_size_reg = cfg_data;
        size_writes++;
      end
      if (out_valid && out_ready) begin
        got.hit    = hit;
        got.misses = miss_total;
        got.atvr   = atvr_q16;
        got.done   = group_done;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result hit=%0b misses=%0d atvr=%0d done=%0b",
                     $realtime, got.hit, got.misses, got.atvr, got.done);
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (got.hit !== want.hit || got.misses !== want.misses ||
              got.atvr !== want.atvr || got.done !== want.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result %0d expected hit=%0b misses=%0d atvr=%0d done=%0b,",
                        " got hit=%0b misses=%0d atvr=%0d done=%0b"},
                       $realtime, results_checked, want.hit, want.misses, want.atvr,
                       want.done, got.hit, got.misses, got.atvr, got.done);
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.insert(awaited_results.size(),
                               vcache_access(vertex_index, last_index));
        indices_taken++;
        if (last_index) groups_closed++;
      end
    end
  end

  task automatic queue_index(input logic [VIDX_W-1:0] v, input logic last);
    index_item_t entry;
    entry.vidx = v;
    entry.last = last;
    index_stream.insert(index_stream.size(), entry);
  endtask

  // Indices cluster around a random base so hits and evictions both occur;
  // about one in ten is an unrelated index.
  task automatic queue_group(input int len, input int span);
    logic [VIDX_W-1:0] base;
    logic [VIDX_W-1:0] v;
    base = $urandom;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) v = $urandom;
      else v = base + $urandom_range(span);
      queue_index(v, k == len - 1);
    end
  endtask

  task automatic wait_idle();
    while (index_stream.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cache_size(input logic [CFG_W-1:0] sz);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] sz;
    int               phase_items;
    int               len;
    int               lim;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset size of 16: a one-index group, then extreme values with hits.
    queue_index(32'h0000_0000, 1'b1);
    queue_index(32'hFFFF_FFFF, 1'b0);
    queue_index(32'hFFFF_FFFF, 1'b0);
    queue_index(32'h0000_0000, 1'b0);
    queue_index(32'h8000_0000, 1'b0);
    queue_index(32'h0000_0000, 1'b0);
    queue_index(32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // With no entries every access misses, even a repeat.
    write_cache_size(6'd0);
    queue_index(32'd5, 1'b0);
    queue_index(32'd5, 1'b0);
    queue_index(32'd5, 1'b1);
    wait_idle();

    // Two entries: the third distinct index pushes out the first.
    write_cache_size(6'd2);
    queue_index(32'd1, 1'b0);
    queue_index(32'd2, 1'b0);
    queue_index(32'd1, 1'b0);
    queue_index(32'd3, 1'b0);
    queue_index(32'd1, 1'b1);
    wait_idle();

    // Shrinking mid-group: old entries still hit until the next miss trims them.
    write_cache_size(6'd4);
    queue_index(32'd10, 1'b0);
    queue_index(32'd11, 1'b0);
    queue_index(32'd12, 1'b0);
    queue_index(32'd13, 1'b0);
    wait_idle();
    write_cache_size(6'd1);
    queue_index(32'd10, 1'b0);
    queue_index(32'd14, 1'b0);
    queue_index(32'd13, 1'b1);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: sz = 6'd1;
        1: sz = 6'd32;
        2: sz = 6'd63;
        3: sz = 6'd33;
        default: sz = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(63))
                                               : CFG_W'($urandom_range(1, 32));
      endcase
      write_cache_size(sz);
      lim = (sz > CACHE_DEPTH) ? CACHE_DEPTH : sz;
      in_idle_pct  = (p == 4) ? 0 : 25;
      out_idle_pct = (p == 4) ? 0 : 25;
      if (p == 6) rx_hold_go = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
        queue_group(len, $urandom_range(1, 2 * lim + 4));
        phase_items += len;
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (awaited_results.size() != 0)
      $display("%0d expected results never arrived", awaited_results.size());
    $display("Checked %0d results for %0d indices in %0d groups.",
             results_checked, indices_taken, groups_closed);
    $display("Cache size written %0d times, from zero through 63, with a long output stall.",
             size_writes);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding", awaited_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fvcm_pkg.sv
sv/fvcm_cell.sv
sv/fvcm_div.sv
sv/fifo_vertex_cache_miss_counter_core.sv
sv/fvcm_checker.sv
bench/fifo_vertex_cache_miss_counter_core_tb.sv
